>>> sv/ssi_pkg.sv
// Shared types and constants of the sorted set intersection block.
package ssi_pkg;

  localparam int unsigned SsiCapacity = 32;
  localparam int unsigned MaxResults  = 32;
  localparam int unsigned ResCntW     = $clog2(MaxResults + 1);
  localparam int unsigned VertexW     = 32;

  typedef enum logic [1:0] {
    CMD_LOAD_FIRST  = 2'd0,
    CMD_LOAD_SECOND = 2'd1,
    CMD_COMPUTE     = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [VertexW-1:0] vertex;
  } req_t;

  typedef struct packed {
    logic [VertexW-1:0] common_vertex;
    logic               found;
    logic               last;
    logic               overflow;
  } res_t;

  // Control of one chain of cells from the sequencer.
  typedef struct packed {
    logic load;
    logic adv;
    logic clear;
  } chain_ctrl_t;

  // Status of one chain seen by the sequencer.
  typedef struct packed {
    logic [VertexW-1:0] head;
    logic               empty;
    logic               full;
  } chain_stat_t;

endpackage

>>> sv/sorted_set_intersection.sv
// Top level of the sorted set intersection block: two cell chains and the merge sequencer.
//
// A request is taken at a clock edge where start_i is high and busy_o is low. A load
// request (first or second set) may follow another load back to back; a load
// into a full set is dropped and sets the sticky overflow flag, which stays set until
// reset and is reported with every result. The sets must be loaded in ascending order
// without duplicates. A compute request walks both chains with the two heads side by side:
// each cycle two comparators look at the two heads and shift one or both chains by a
// cell, until either set is empty or MaxResults matches are found; a closing step follows,
// and busy_o is high for all of it. Each match is held back until the next match or the
// closing step so that the final one can be marked last; results come out on res_o for a
// single cycle with res_strobe_o high, and the receiver cannot stall them. An empty
// intersection gives a single result with found and common_vertex at zero and last set.
// The last result appears in the first cycle in which busy_o is low again, and both sets
// are then empty. At most MaxResults results come from one compute.
// Command code 3 is ignored.
module sorted_set_intersection import ssi_pkg::*; #(
  parameter int unsigned Capacity = SsiCapacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic res_strobe_o,
  output res_t res_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_e;

  state_e state_d, state_q;

  chain_ctrl_t ctrl_a, ctrl_b;
  chain_stat_t stat_a, stat_b;

  logic               accept;
  logic               ovf_d, ovf_q;
  logic [ResCntW-1:0] n_d, n_q;
  logic               pend_v_d, pend_v_q;
  logic [VertexW-1:0] pend_d, pend_q;
  logic               strobe_d, strobe_q;
  res_t               res_d, res_q;

  logic walk_go, a_lt, b_lt;

  assign accept = start_i && (state_q == ST_IDLE);

  // The walk carries on while both sets still hold entries and the result budget lasts.
  assign walk_go = !stat_a.empty && !stat_b.empty && (n_q != ResCntW'(MaxResults));
  assign a_lt    = stat_a.head < stat_b.head;
  assign b_lt    = stat_b.head < stat_a.head;

  ssi_chain #(.Capacity(Capacity)) u_chain_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl_a),
    .vertex_i (req_i.vertex),
    .stat_o   (stat_a)
  );

  ssi_chain #(.Capacity(Capacity)) u_chain_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl_b),
    .vertex_i (req_i.vertex),
    .stat_o   (stat_b)
  );

  always_comb begin
    state_d  = state_q;
    ovf_d    = ovf_q;
    n_d      = n_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    ctrl_a   = '0;
    ctrl_b   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i.cmd)
            CMD_LOAD_FIRST: begin
              ctrl_a.load = 1'b1;
              if (stat_a.full) begin
                ovf_d = 1'b1;
              end
            end
            CMD_LOAD_SECOND: begin
              ctrl_b.load = 1'b1;
              if (stat_b.full) begin
                ovf_d = 1'b1;
              end
            end
            CMD_COMPUTE: begin
              state_d  = ST_WALK;
              n_d      = '0;
              pend_v_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        if (walk_go) begin
          ctrl_a.adv = !b_lt;
          ctrl_b.adv = !a_lt;
          if (!a_lt && !b_lt) begin
            // A match: release the one held back, keep this one for now.
            if (pend_v_q) begin
              strobe_d = 1'b1;
              res_d    = '{common_vertex: pend_q, found: 1'b1, last: 1'b0,
                           overflow: ovf_q};
            end
            pend_d   = stat_a.head;
            pend_v_d = 1'b1;
            n_d      = n_q + ResCntW'(1);
          end
        end else begin
          strobe_d = 1'b1;
          if (pend_v_q) begin
            res_d = '{common_vertex: pend_q, found: 1'b1, last: 1'b1, overflow: ovf_q};
          end else begin
            res_d = '{common_vertex: '0, found: 1'b0, last: 1'b1, overflow: ovf_q};
          end
          ctrl_a.clear = 1'b1;
          ctrl_b.clear = 1'b1;
          pend_v_d     = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovf_q    <= 1'b0;
      n_q      <= '0;
      pend_v_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovf_q    <= ovf_d;
      n_q      <= n_d;
      pend_v_q <= pend_v_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    res_q  <= res_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

>>> sv/ssi_cell.sv
// One storage cell of a set chain: takes a loaded vertex or its neighbour's value.
module ssi_cell import ssi_pkg::*; (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic               adv_i,
  input  logic [VertexW-1:0] load_data_i,
  input  logic [VertexW-1:0] next_data_i,
  output logic [VertexW-1:0] data_o
);

  logic [VertexW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end else if (adv_i) begin
      data_q <= next_data_i;
    end
  end

  assign data_o = data_q;

endmodule

>>> sv/ssi_chain.sv
// A row of cells holding one set, with its fill count; the head sits in cell 0.
module ssi_chain import ssi_pkg::*; #(
  parameter int unsigned Capacity = SsiCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  chain_ctrl_t        ctrl_i,
  input  logic [VertexW-1:0] vertex_i,
  output chain_stat_t        stat_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic [CntW-1:0]                  cnt_d, cnt_q;
  logic [Capacity-1:0][VertexW-1:0] data;
  logic                             full, empty;

  assign full  = (cnt_q == CntW'(Capacity));
  assign empty = (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    priority if (ctrl_i.clear) begin
      cnt_d = '0;
    end else if (ctrl_i.load && !full) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (ctrl_i.adv && !empty) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [VertexW-1:0] next_data;
    if (i == Capacity - 1) begin : g_tail
      assign next_data = data[i];
    end else begin : g_body
      assign next_data = data[i+1];
    end
    ssi_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (ctrl_i.load && !full && (cnt_q == CntW'(i))),
      .adv_i       (ctrl_i.adv),
      .load_data_i (vertex_i),
      .next_data_i (next_data),
      .data_o      (data[i])
    );
  end

  assign stat_o.head  = data[0];
  assign stat_o.empty = empty;
  assign stat_o.full  = full;

endmodule

>>> sv/ssi_checker.sv
// Port-level checks of the sorted set intersection block and their binding.
module ssi_checker import ssi_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input req_t req_i,
  input logic busy_o,
  input logic res_strobe_o,
  input res_t res_o
);

  // A not-found result is always the only and last one, with a zero vertex.
  a_notfound_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.found) |-> (res_o.last && (res_o.common_vertex == '0)))
    else $error("not-found result is not a lone final result");

  // Leaving the walk always delivers the final result of that compute.
  a_end_gives_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (res_strobe_o && res_o.last))
    else $error("compute ended without a final result");

  // Results only come from a compute that was running in the previous cycle.
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(busy_o))
    else $error("result without a running compute");

  // Once reported, overflow stays set until reset.
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.overflow) |=> (!res_strobe_o || res_o.overflow))
    else $error("overflow flag cleared without reset");

endmodule

bind sorted_set_intersection ssi_checker u_ssi_checker (.*);
